// File: hdl/rrts_pkg.sv
// Shared types, codes and default sizes for the round-robin thread scheduler.
package rrts_pkg;

   localparam int MaxSlotsDef    = 128;
   localparam int NumMutexesDef  = 16;
   localparam int NumBarriersDef = 16;

   localparam int ActW     = 4;
   localparam int ObjW     = 4;
   localparam int SizeW    = 8;
   localparam int StatW    = 3;
   localparam int ValW     = 7;
   localparam int SlotOutW = 7;

   typedef enum logic [ActW-1:0] {
      ACT_CREATE   = 4'd0,
      ACT_TICK     = 4'd1,
      ACT_EXIT     = 4'd2,
      ACT_MINIT    = 4'd3,
      ACT_MDESTROY = 4'd4,
      ACT_LOCK     = 4'd5,
      ACT_UNLOCK   = 4'd6,
      ACT_BINIT    = 4'd7,
      ACT_BDESTROY = 4'd8,
      ACT_BWAIT    = 4'd9
   } action_type;

   typedef enum logic [2:0] {
      ST_EMPTY   = 3'd0,
      ST_READY   = 3'd1,
      ST_RUNNING = 3'd2,
      ST_BLOCKED = 3'd3,
      ST_WAITING = 3'd4,
      ST_EXITED  = 3'd5
   } slot_state_type;

   typedef enum logic [StatW-1:0] {
      RS_OK      = 3'd0,
      RS_BUSY    = 3'd1,
      RS_INVALID = 3'd2,
      RS_FULL    = 3'd3,
      RS_DONE    = 3'd4
   } rsp_status_type;

   typedef enum logic [1:0] {
      SCAN_EMPTY,
      SCAN_BLOCKED,
      SCAN_WAKE,
      SCAN_READY
   } scan_mode_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_FIND_GO,
      FSM_FIND_RUN,
      FSM_WAKE_GO,
      FSM_WAKE_RUN,
      FSM_CUR_RD,
      FSM_CUR_WR,
      FSM_PICK_GO,
      FSM_PICK_RUN,
      FSM_PICK_END,
      FSM_RESP
   } fsm_state_type;

   typedef struct packed {
      logic          load;
      logic          exec;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          cur_rd;
      logic          cur_wr;
      logic          pick_end;
      logic          rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       m_ok;
      logic       m_locked;
      logic       b_ok;
      logic       b_last;
      logic       scan_busy;
   } dp_stat_type;

endpackage

// File: hdl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler: controller plus datapath.
//
//   channel | ports                                               | dir
//   req     | req_valid/ready, action, object_index, barrier_size  | in
//   rsp     | rsp_valid/ready, status, value, running_slot         | out
//
// One event at a time. Table-only events go from accept through decode straight to
// the response state. Create and a valid unlock run one slot-table scan. Tick, exit,
// blocking lock and barrier wait read-modify-write the current slot and scan the
// other slots; a barrier release adds a full wake scan first. The single read port
// of the slot memory sets the one-slot-per-cycle scan rate. Reset is synchronous
// and needs no clearing pass. A stalled result is held while the next event is
// accepted.
module round_robin_thread_scheduler #(
   parameter int MAX_SLOTS    = rrts_pkg::MaxSlotsDef,
   parameter int NUM_MUTEXES  = rrts_pkg::NumMutexesDef,
   parameter int NUM_BARRIERS = rrts_pkg::NumBarriersDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rrts_pkg::ActW-1:0]     req_action,
   input  logic [rrts_pkg::ObjW-1:0]     req_object_index,
   input  logic [rrts_pkg::SizeW-1:0]    req_barrier_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rrts_pkg::StatW-1:0]    rsp_status,
   output logic [rrts_pkg::ValW-1:0]     rsp_value,
   output logic [rrts_pkg::SlotOutW-1:0] rsp_running_slot
);
   import rrts_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrts_dpath #(
      .MAX_SLOTS    (MAX_SLOTS),
      .NUM_MUTEXES  (NUM_MUTEXES),
      .NUM_BARRIERS (NUM_BARRIERS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_object_index (req_object_index),
      .req_barrier_size (req_barrier_size),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_value        (rsp_value),
      .rsp_running_slot (rsp_running_slot)
   );

endmodule

// File: hdl/rrts_ctrl.sv
// Controller state machine that sequences decode, slot scans and scheduling.
module rrts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rrts_pkg::dp_stat_type stat,
   output rrts_pkg::ctl_cmd_type cmd
);
   import rrts_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_DECODE;
         end
         FSM_DECODE: begin
            case (stat.action)
               ACT_CREATE: state_in = FSM_FIND_GO;
               ACT_TICK, ACT_EXIT: state_in = FSM_CUR_RD;
               ACT_LOCK: state_in = (stat.m_ok && stat.m_locked) ? FSM_CUR_RD : FSM_RESP;
               ACT_UNLOCK: state_in = stat.m_ok ? FSM_FIND_GO : FSM_RESP;
               ACT_BWAIT: begin
                  if (!stat.b_ok) state_in = FSM_RESP;
                  else if (stat.b_last) state_in = FSM_WAKE_GO;
                  else state_in = FSM_CUR_RD;
               end
               default: state_in = FSM_RESP;
            endcase
         end
         FSM_FIND_GO:  state_in = FSM_FIND_RUN;
         FSM_FIND_RUN: begin
            if (!stat.scan_busy) state_in = FSM_RESP;
         end
         FSM_WAKE_GO:  state_in = FSM_WAKE_RUN;
         FSM_WAKE_RUN: begin
            if (!stat.scan_busy) state_in = FSM_CUR_RD;
         end
         FSM_CUR_RD:   state_in = FSM_CUR_WR;
         FSM_CUR_WR:   state_in = FSM_PICK_GO;
         FSM_PICK_GO:  state_in = FSM_PICK_RUN;
         FSM_PICK_RUN: begin
            if (!stat.scan_busy) state_in = FSM_PICK_END;
         end
         FSM_PICK_END: state_in = FSM_RESP;
         FSM_RESP: begin
            if (rsp_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.scan_mode = SCAN_EMPTY;
      cmd.load = req_valid && (state_ff == FSM_IDLE);
      unique case (state_ff)
         FSM_DECODE:   cmd.exec = 1'b1;
         FSM_FIND_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = (stat.action == ACT_CREATE) ? SCAN_EMPTY : SCAN_BLOCKED;
         end
         FSM_WAKE_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_WAKE;
         end
         FSM_PICK_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_READY;
         end
         FSM_CUR_RD:   cmd.cur_rd   = 1'b1;
         FSM_CUR_WR:   cmd.cur_wr   = 1'b1;
         FSM_PICK_END: cmd.pick_end = 1'b1;
         FSM_RESP:     cmd.rsp_load = rsp_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/rrts_dpath.sv
// Datapath: slot table memory, scan engine, mutex and barrier tables, result registers.
module rrts_dpath #(
   parameter int MAX_SLOTS    = rrts_pkg::MaxSlotsDef,
   parameter int NUM_MUTEXES  = rrts_pkg::NumMutexesDef,
   parameter int NUM_BARRIERS = rrts_pkg::NumBarriersDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rrts_pkg::ActW-1:0]     req_action,
   input  logic [rrts_pkg::ObjW-1:0]     req_object_index,
   input  logic [rrts_pkg::SizeW-1:0]    req_barrier_size,
   input  rrts_pkg::ctl_cmd_type         cmd,
   output rrts_pkg::dp_stat_type         stat,
   output logic [rrts_pkg::StatW-1:0]    rsp_status,
   output logic [rrts_pkg::ValW-1:0]     rsp_value,
   output logic [rrts_pkg::SlotOutW-1:0] rsp_running_slot
);
   import rrts_pkg::*;

   localparam int SW  = $clog2(MAX_SLOTS);
   localparam int SW1 = SW + 1;
   localparam int CW  = $clog2(MAX_SLOTS + 1);
   localparam int MIW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
   localparam int MNW = $clog2(NUM_MUTEXES + 1);
   localparam int BIW = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1;
   localparam int BNW = $clog2(NUM_BARRIERS + 1);
   localparam int EW  = 3 + ObjW;
   localparam logic [CW-1:0]  NAll   = CW'(MAX_SLOTS);
   localparam logic [CW-1:0]  NPick  = CW'(MAX_SLOTS - 1);
   localparam logic [SW1-1:0] SlotsX = SW1'(MAX_SLOTS);
   localparam logic [SW-1:0]  LastSlot = SW'(MAX_SLOTS - 1);

   // latched event
   action_type       act_ff;
   logic [ObjW-1:0]  obj_ff;
   logic [SizeW-1:0] size_ff;

   // slot table
   logic [EW-1:0]   slot_mem [MAX_SLOTS];
   logic            vld_ff   [MAX_SLOTS];
   logic [EW-1:0]   rd_data_ff;
   logic            rd_init_ff;
   logic [SW-1:0]   rd_slot_ff;
   logic            rd_scan_ff, rd_last_ff;
   logic            rd_en;
   logic [SW-1:0]   rd_addr;
   slot_state_type  eff_st;
   logic [ObjW-1:0] eff_tag;
   logic            we;
   logic [SW-1:0]   wa;
   slot_state_type  wd_st;
   logic [ObjW-1:0] wd_tag;

   // scan engine
   logic            scan_active_ff;
   scan_mode_type   scan_mode_ff;
   logic [CW-1:0]   iss_cnt_ff;
   logic [SW-1:0]   base_ff;
   logic [CW-1:0]   scan_n;
   logic            issue, iss_last, eval, match, stop;
   logic [SW1-1:0]  addr_sum, addr_wrap;
   logic [SW-1:0]   scan_addr;
   logic            pick_found_ff;

   // object tables
   logic             m_init_ff   [NUM_MUTEXES];
   logic             m_locked_ff [NUM_MUTEXES];
   logic             b_valid_ff  [NUM_BARRIERS];
   logic [SizeW-1:0] b_rem_ff    [NUM_BARRIERS];
   logic [SizeW-1:0] b_cnt_ff    [NUM_BARRIERS];
   logic [MNW-1:0]   mnext_ff;
   logic [BNW-1:0]   bnext_ff;
   logic [MIW-1:0]   m_idx, mnext_idx;
   logic [BIW-1:0]   b_idx, bnext_idx;
   logic             m_range, m_ok, m_locked, m_full;
   logic             b_range, b_ok, b_last, b_busy, b_full;

   // scheduling state and results
   logic [SW-1:0]   cur_ff;
   slot_state_type  cur_st_ff, cur_new_st;
   logic [ObjW-1:0] cur_tag_ff, cur_new_tag;
   logic            release_ff;
   rsp_status_type  res_status_ff, exec_status;
   logic [ValW-1:0] res_value_ff, exec_value;
   rsp_status_type  rsp_status_ff;
   logic [ValW-1:0] rsp_value_ff;
   logic [SlotOutW-1:0] rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= action_type'(req_action);
         obj_ff  <= req_object_index;
         size_ff <= req_barrier_size;
      end
   end

   // ---------------- object table lookups ----------------
   assign m_idx     = MIW'(obj_ff);
   assign b_idx     = BIW'(obj_ff);
   assign mnext_idx = MIW'(mnext_ff);
   assign bnext_idx = BIW'(bnext_ff);
   assign m_range   = 32'(obj_ff) < NUM_MUTEXES;
   assign b_range   = 32'(obj_ff) < NUM_BARRIERS;
   assign m_ok      = m_range && m_init_ff[m_idx];
   assign m_locked  = m_locked_ff[m_idx];
   assign m_full    = mnext_ff >= MNW'(NUM_MUTEXES);
   assign b_ok      = b_range && b_valid_ff[b_idx];
   assign b_last    = (b_rem_ff[b_idx] == SizeW'(1));
   assign b_busy    = b_valid_ff[b_idx] && (b_rem_ff[b_idx] < b_cnt_ff[b_idx]);
   assign b_full    = bnext_ff >= BNW'(NUM_BARRIERS);

   assign stat.action    = act_ff;
   assign stat.m_ok      = m_ok;
   assign stat.m_locked  = m_locked;
   assign stat.b_ok      = b_ok;
   assign stat.b_last    = b_last;
   assign stat.scan_busy = scan_active_ff;

   // ---------------- scan engine ----------------
   assign scan_n    = (scan_mode_ff == SCAN_READY) ? NPick : NAll;
   assign issue     = scan_active_ff && (iss_cnt_ff < scan_n);
   assign iss_last  = (iss_cnt_ff == scan_n - 1'b1);
   assign addr_sum  = SW1'(base_ff) + SW1'(iss_cnt_ff);
   assign addr_wrap = (addr_sum >= SlotsX) ? addr_sum - SlotsX : addr_sum;
   assign scan_addr = addr_wrap[SW-1:0];
   assign eval      = rd_scan_ff && scan_active_ff;

   always_comb begin
      case (scan_mode_ff)
         SCAN_EMPTY:   match = (eff_st == ST_EMPTY);
         SCAN_BLOCKED: match = (eff_st == ST_BLOCKED) && (eff_tag == obj_ff);
         SCAN_WAKE:    match = (eff_st == ST_WAITING) && (eff_tag == obj_ff);
         default:      match = (eff_st == ST_READY);
      endcase
   end

   assign stop = eval && ((match && (scan_mode_ff != SCAN_WAKE)) || rd_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         rd_scan_ff     <= 1'b0;
      end else begin
         rd_scan_ff <= issue;
         if (cmd.scan_start) scan_active_ff <= 1'b1;
         else if (stop) scan_active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_mode_ff  <= cmd.scan_mode;
         iss_cnt_ff    <= '0;
         pick_found_ff <= 1'b0;
         base_ff       <= (cmd.scan_mode != SCAN_READY) ? '0 :
                          (cur_ff == LastSlot) ? '0 : cur_ff + 1'b1;
      end else if (issue) begin
         iss_cnt_ff <= iss_cnt_ff + 1'b1;
      end
      if (eval && match && (scan_mode_ff == SCAN_READY)) pick_found_ff <= 1'b1;
      rd_last_ff <= issue && iss_last;
   end

   // ---------------- slot table ----------------
   assign rd_en   = issue || cmd.cur_rd;
   assign rd_addr = issue ? scan_addr : cur_ff;

   always_ff @(posedge clock) begin
      if (we) slot_mem[wa] <= {wd_st, wd_tag};
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
         rd_init_ff <= vld_ff[rd_addr];
         rd_slot_ff <= rd_addr;
      end
   end

   // an entry never written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) vld_ff[i] <= 1'b0;
      end else if (we) begin
         vld_ff[wa] <= 1'b1;
      end
   end

   always_comb begin
      if (rd_init_ff) begin
         eff_st  = slot_state_type'(rd_data_ff[EW-1:ObjW]);
         eff_tag = rd_data_ff[ObjW-1:0];
      end else begin
         eff_st  = (rd_slot_ff == '0) ? ST_RUNNING : ST_EMPTY;
         eff_tag = '0;
      end
   end

   always_comb begin
      cur_new_st  = eff_st;
      cur_new_tag = eff_tag;
      case (act_ff)
         ACT_EXIT: cur_new_st = ST_EXITED;
         ACT_LOCK: begin
            cur_new_st  = ST_BLOCKED;
            cur_new_tag = obj_ff;
         end
         ACT_BWAIT: begin
            if (!release_ff) begin
               cur_new_st  = ST_WAITING;
               cur_new_tag = obj_ff;
            end
         end
         default: ;
      endcase
      if (cur_new_st == ST_RUNNING) cur_new_st = ST_READY;
   end

   always_comb begin
      we     = 1'b0;
      wa     = rd_slot_ff;
      wd_st  = ST_READY;
      wd_tag = '0;
      if (eval && match) begin
         we = 1'b1;
         if (scan_mode_ff == SCAN_READY) begin
            wd_st  = ST_RUNNING;
            wd_tag = eff_tag;
         end
      end else if (cmd.cur_wr) begin
         we     = 1'b1;
         wa     = cur_ff;
         wd_st  = cur_new_st;
         wd_tag = cur_new_tag;
      end else if (cmd.pick_end && !pick_found_ff && (cur_st_ff == ST_READY)) begin
         we     = 1'b1;
         wa     = cur_ff;
         wd_st  = ST_RUNNING;
         wd_tag = cur_tag_ff;
      end
   end

   // ---------------- object tables ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MUTEXES; i++) begin
            m_init_ff[i]   <= 1'b0;
            m_locked_ff[i] <= 1'b0;
         end
         for (int i = 0; i < NUM_BARRIERS; i++) b_valid_ff[i] <= 1'b0;
         mnext_ff <= '0;
         bnext_ff <= '0;
      end else begin
         if (cmd.exec) begin
            case (act_ff)
               ACT_MINIT: begin
                  if (!m_full) begin
                     m_init_ff[mnext_idx]   <= 1'b1;
                     m_locked_ff[mnext_idx] <= 1'b0;
                     mnext_ff               <= mnext_ff + 1'b1;
                  end
               end
               ACT_MDESTROY: begin
                  if (m_range && !m_locked) m_init_ff[m_idx] <= 1'b0;
               end
               ACT_LOCK: begin
                  if (m_ok && !m_locked) m_locked_ff[m_idx] <= 1'b1;
               end
               ACT_BINIT: begin
                  if ((size_ff != '0) && !b_full) begin
                     b_valid_ff[bnext_idx] <= 1'b1;
                     bnext_ff              <= bnext_ff + 1'b1;
                  end
               end
               ACT_BDESTROY: begin
                  if (b_range && !b_busy) b_valid_ff[b_idx] <= 1'b0;
               end
               default: ;
            endcase
         end
         // no waiter found: free the mutex
         if (eval && !match && rd_last_ff && (scan_mode_ff == SCAN_BLOCKED))
            m_locked_ff[m_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         case (act_ff)
            ACT_BINIT: begin
               if ((size_ff != '0) && !b_full) begin
                  b_cnt_ff[bnext_idx] <= size_ff;
                  b_rem_ff[bnext_idx] <= size_ff;
               end
            end
            ACT_BDESTROY: begin
               if (b_range && !b_busy) begin
                  b_cnt_ff[b_idx] <= '0;
                  b_rem_ff[b_idx] <= '0;
               end
            end
            ACT_BWAIT: begin
               if (b_ok) b_rem_ff[b_idx] <= b_last ? b_cnt_ff[b_idx] : b_rem_ff[b_idx] - 1'b1;
            end
            default: ;
         endcase
      end
   end

   // ---------------- results ----------------
   always_comb begin
      exec_status = RS_OK;
      exec_value  = '0;
      case (act_ff)
         ACT_CREATE, ACT_TICK, ACT_EXIT: ;
         ACT_MINIT: begin
            if (m_full) exec_status = RS_FULL;
            else exec_value = ValW'(mnext_ff);
         end
         ACT_MDESTROY: begin
            if (!m_range) exec_status = RS_INVALID;
            else if (m_locked) exec_status = RS_BUSY;
         end
         ACT_LOCK, ACT_UNLOCK: begin
            if (!m_ok) exec_status = RS_INVALID;
         end
         ACT_BINIT: begin
            if (size_ff == '0) exec_status = RS_INVALID;
            else if (b_full) exec_status = RS_FULL;
            else exec_value = ValW'(bnext_ff);
         end
         ACT_BDESTROY: begin
            if (!b_range) exec_status = RS_INVALID;
            else if (b_busy) exec_status = RS_BUSY;
         end
         ACT_BWAIT: begin
            if (!b_ok) exec_status = RS_INVALID;
            else exec_value = {{(ValW-1){1'b0}}, b_last};
         end
         default: exec_status = RS_INVALID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else if (eval && match && (scan_mode_ff == SCAN_READY)) begin
         cur_ff <= rd_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_status_ff <= exec_status;
         res_value_ff  <= exec_value;
         release_ff    <= b_last;
      end
      if (eval && (scan_mode_ff == SCAN_EMPTY)) begin
         if (match) res_value_ff <= ValW'(rd_slot_ff);
         else if (rd_last_ff) res_status_ff <= RS_FULL;
      end
      if (cmd.cur_wr) begin
         cur_st_ff  <= cur_new_st;
         cur_tag_ff <= cur_new_tag;
      end
      // no other slot ready and the current one cannot go on
      if (cmd.pick_end && !pick_found_ff && (cur_st_ff != ST_READY))
         res_status_ff <= RS_DONE;
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_slot_ff   <= SlotOutW'(cur_ff);
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_running_slot = rsp_slot_ff;

endmodule

// File: tb/round_robin_thread_scheduler_tb.sv
// Self-checking testbench for the round-robin thread scheduler.
`timescale 1ns / 1ps

module round_robin_thread_scheduler_tb;
   import rrts_pkg::*;

   localparam int NSLOT      = 128;
   localparam int NMUTEX     = 16;
   localparam int NBARRIER   = 16;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [3:0] action;
      logic [3:0] obj;
      logic [7:0] size;
      bit         drain;
   } event_item_t;

   typedef struct {
      logic [2:0] status;
      logic [6:0] value;
      logic [6:0] slot;
   } sched_result_t;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [3:0] req_action;
   logic [3:0] req_object_index;
   logic [7:0] req_barrier_size;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_status;
   logic [6:0] rsp_value;
   logic [6:0] rsp_running_slot;

   event_item_t   pending_events[$];
   sched_result_t expected_results[$];

   // scheduler shadow state
   slot_state_type thread_state[NSLOT];
   logic [3:0]     thread_tag[NSLOT];
   int             run_slot;
   bit             mtx_init[NMUTEX];
   bit             mtx_locked[NMUTEX];
   int             mtx_owner[NMUTEX];
   bit             bar_valid[NBARRIER];
   logic [7:0]     bar_left[NBARRIER];
   logic [7:0]     bar_count[NBARRIER];
   int             mtx_alloc;
   int             bar_alloc;

   bit  req_fire;
   int  errors;
   int  cycles;
   int  burst_left;
   int  gap_left;
   int  hold_left;
   bit  hold_done;
   int  accepted_count;
   int  stall_mode;

   round_robin_thread_scheduler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_object_index (req_object_index),
      .req_barrier_size (req_barrier_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value        (rsp_value),
      .rsp_running_slot (rsp_running_slot)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [2:0] schedule_next();
      if (thread_state[run_slot] == ST_RUNNING) thread_state[run_slot] = ST_READY;
      for (int k = 1; k <= NSLOT; k++) begin
         int s;
         s = (run_slot + k) % NSLOT;
         if (thread_state[s] == ST_READY) begin
            thread_state[s] = ST_RUNNING;
            run_slot = s;
            return RS_OK;
         end
      end
      return RS_DONE;
   endfunction

   function automatic sched_result_t apply_event(event_item_t ev);
      sched_result_t r;
      int o;
      int s;
      o = ev.obj;
      r.status = RS_OK;
      r.value  = '0;
      case (ev.action)
         ACT_CREATE: begin
            r.status = RS_FULL;
            for (s = 0; s < NSLOT; s++) begin
               if (thread_state[s] == ST_EMPTY) begin
                  thread_state[s] = ST_READY;
                  thread_tag[s] = '0;
                  r.value = s;
                  r.status = RS_OK;
                  break;
               end
            end
         end
         ACT_TICK: r.status = schedule_next();
         ACT_EXIT: begin
            thread_state[run_slot] = ST_EXITED;
            r.status = schedule_next();
         end
         ACT_MINIT: begin
            if (mtx_alloc >= NMUTEX) r.status = RS_FULL;
            else begin
               mtx_init[mtx_alloc] = 1;
               mtx_locked[mtx_alloc] = 0;
               mtx_owner[mtx_alloc] = 0;
               r.value = mtx_alloc;
               mtx_alloc++;
            end
         end
         ACT_MDESTROY: begin
            if (mtx_locked[o]) r.status = RS_BUSY;
            else begin
               mtx_init[o] = 0;
               mtx_owner[o] = 0;
            end
         end
         ACT_LOCK: begin
            if (!mtx_init[o]) r.status = RS_INVALID;
            else if (mtx_locked[o]) begin
               thread_state[run_slot] = ST_BLOCKED;
               thread_tag[run_slot] = o;
               r.status = schedule_next();
            end else begin
               mtx_locked[o] = 1;
               mtx_owner[o] = run_slot;
            end
         end
         ACT_UNLOCK: begin
            if (!mtx_init[o]) r.status = RS_INVALID;
            else begin
               for (s = 0; s < NSLOT; s++)
                  if (thread_state[s] == ST_BLOCKED && thread_tag[s] == o) break;
               if (s < NSLOT) begin
                  // hand ownership to the first blocked waiter
                  thread_state[s] = ST_READY;
                  thread_tag[s] = '0;
                  mtx_owner[o] = s;
               end else begin
                  mtx_locked[o] = 0;
                  mtx_owner[o] = 0;
               end
            end
         end
         ACT_BINIT: begin
            if (ev.size == 0) r.status = RS_INVALID;
            else if (bar_alloc >= NBARRIER) r.status = RS_FULL;
            else begin
               bar_valid[bar_alloc] = 1;
               bar_count[bar_alloc] = ev.size;
               bar_left[bar_alloc] = ev.size;
               r.value = bar_alloc;
               bar_alloc++;
            end
         end
         ACT_BDESTROY: begin
            if (bar_valid[o] && bar_left[o] < bar_count[o]) r.status = RS_BUSY;
            else begin
               bar_valid[o] = 0;
               bar_count[o] = '0;
               bar_left[o] = '0;
            end
         end
         ACT_BWAIT: begin
            if (!bar_valid[o]) r.status = RS_INVALID;
            else begin
               bar_left[o] = bar_left[o] - 8'd1;
               if (bar_left[o] == 0) begin
                  // last arrival releases every waiter
                  for (s = 0; s < NSLOT; s++) begin
                     if (thread_state[s] == ST_WAITING && thread_tag[s] == o) begin
                        thread_state[s] = ST_READY;
                        thread_tag[s] = '0;
                     end
                  end
                  bar_left[o] = bar_count[o];
                  r.value = 1;
               end else begin
                  thread_state[run_slot] = ST_WAITING;
                  thread_tag[run_slot] = o;
               end
               r.status = schedule_next();
            end
         end
         default: r.status = RS_INVALID;
      endcase
      r.slot = run_slot;
      return r;
   endfunction

   task automatic add_event(logic [3:0] a, logic [3:0] o, logic [7:0] sz, bit d = 0);
      event_item_t ev;
      ev.action = a;
      ev.obj = o;
      ev.size = sz;
      ev.drain = d;
      pending_events.push_back(ev);
   endtask

   function automatic logic [7:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd128;
      if (r == 2) return $urandom_range(0, 255);
      return $urandom_range(1, 4);
   endfunction

   // fill the stimulus queue
   initial begin
      int w;
      logic [3:0] a;
      for (int i = 0; i < NSLOT; i++) begin
         thread_state[i] = (i == 0) ? ST_RUNNING : ST_EMPTY;
         thread_tag[i] = '0;
      end
      for (int i = 0; i < NMUTEX; i++) begin
         mtx_init[i] = 0; mtx_locked[i] = 0; mtx_owner[i] = 0;
      end
      for (int i = 0; i < NBARRIER; i++) begin
         bar_valid[i] = 0; bar_left[i] = '0; bar_count[i] = '0;
      end
      run_slot = 0;
      mtx_alloc = 0;
      bar_alloc = 0;

      // directed part
      add_event(ACT_TICK, 4'd0, 8'd0);
      add_event(ACT_LOCK, 4'd0, 8'd0);
      add_event(ACT_UNLOCK, 4'd15, 8'd0);
      add_event(ACT_BWAIT, 4'd15, 8'd0);
      add_event(ACT_CREATE, 4'd0, 8'd0);
      add_event(ACT_CREATE, 4'd0, 8'd0);
      add_event(ACT_MINIT, 4'd0, 8'd0);
      add_event(ACT_LOCK, 4'd0, 8'd0);
      add_event(ACT_MDESTROY, 4'd0, 8'd0);
      add_event(ACT_LOCK, 4'd0, 8'd0);
      add_event(ACT_UNLOCK, 4'd0, 8'd0);
      add_event(ACT_UNLOCK, 4'd0, 8'd0);
      add_event(ACT_MDESTROY, 4'd15, 8'd0);
      add_event(ACT_BINIT, 4'd0, 8'd0);
      add_event(ACT_BINIT, 4'd0, 8'd2);
      add_event(ACT_BINIT, 4'd0, 8'd255);
      add_event(ACT_BWAIT, 4'd0, 8'd0);
      add_event(ACT_BDESTROY, 4'd0, 8'd0);
      add_event(ACT_BWAIT, 4'd0, 8'd0);
      add_event(ACT_BDESTROY, 4'd0, 8'd0);
      add_event(ACT_BDESTROY, 4'd15, 8'd0);
      add_event(4'd10, 4'd5, 8'd0);
      add_event(4'd15, 4'd10, 8'd170);
      add_event(ACT_EXIT, 4'd0, 8'd0);
      add_event(ACT_TICK, 4'd0, 8'd0, 1);

      // random part
      for (int i = 0; i < 1880; i++) begin
         w = $urandom_range(0, 99);
         if (w < 9)       a = ACT_CREATE;
         else if (w < 27) a = ACT_TICK;
         else if (w < 32) a = ACT_EXIT;
         else if (w < 37) a = ACT_MINIT;
         else if (w < 41) a = ACT_MDESTROY;
         else if (w < 56) a = ACT_LOCK;
         else if (w < 72) a = ACT_UNLOCK;
         else if (w < 78) a = ACT_BINIT;
         else if (w < 82) a = ACT_BDESTROY;
         else if (w < 97) a = ACT_BWAIT;
         else             a = $urandom_range(10, 15);
         add_event(a, (a == ACT_LOCK || a == ACT_UNLOCK || a == ACT_BWAIT)
                      ? $urandom_range(0, 3) : $urandom_range(0, 15),
                   pick_size(), i == 900);
      end
   end

   // reset and end of run
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = '0;
      req_object_index = '0;
      req_barrier_size = '0;
      rsp_ready = 1'b0;
      errors = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_events.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (300) @(posedge clock);
      if (expected_results.size() == 0 && errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end
   initial cycles = 0;

   // driver: bursts with random gaps, waits for drain where flagged
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= $urandom_range(1, 20);
         gap_left <= 0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_events.size() > 0 &&
                      !(pending_events[0].drain && expected_results.size() != 0)) begin
            event_item_t ev;
            ev = pending_events.pop_front();
            req_valid <= 1'b1;
            req_action <= ev.action;
            req_object_index <= ev.obj;
            req_barrier_size <= ev.size;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            end else
               burst_left <= burst_left - 1;
         end else
            req_valid <= 1'b0;
      end
   end

   // receiver stall pattern with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 0;
         stall_mode <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_count >= 400) begin
         rsp_ready <= 1'b0;
         hold_left <= 2000;
         hold_done <= 1;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: check results, then predict the newly accepted item
   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      if (reset) begin
         accepted_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: status %0d", rsp_status);
               errors++;
            end else begin
               sched_result_t e;
               e = expected_results.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_value !== e.value) begin
                  $error("value: expected %0d, got %0d", e.value, rsp_value);
                  errors++;
               end
               if (rsp_running_slot !== e.slot) begin
                  $error("running_slot: expected %0d, got %0d", e.slot, rsp_running_slot);
                  errors++;
               end
            end
         end
         if (req_fire) begin
            event_item_t ev;
            ev.action = req_action;
            ev.obj = req_object_index;
            ev.size = req_barrier_size;
            ev.drain = 0;
            expected_results.push_back(apply_event(ev));
            accepted_count++;
         end
      end
   end

endmodule

// File: files.f
hdl/rrts_pkg.sv
hdl/rrts_ctrl.sv
hdl/rrts_dpath.sv
hdl/round_robin_thread_scheduler.sv
tb/round_robin_thread_scheduler_tb.sv
